/* src/landmark_odometry_measurement_defines.svh */
// Assertion macros shared by the landmark odometry measurement RTL.
`ifndef LANDMARK_ODOMETRY_MEASUREMENT_DEFINES_SVH
`define LANDMARK_ODOMETRY_MEASUREMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define LOM_CHECK_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lomeas check failed");
`define LOM_CHECK_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lomeas check failed");
`else
`define LOM_CHECK_IMP(label, ante, cons)
`define LOM_CHECK_NXT(label, ante, cons)
`endif
`endif

/* src/lomeas_pkg.sv */
// Types, constants and helper functions of the landmark odometry measurement block.
package lomeas_pkg;

    // CORDIC iteration count, capped by the arctangent table depth
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_DEPTH   = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;

    localparam int XY_W  = 50;  // CORDIC datapath width
    localparam int IO_W  = 18;  // rotator input and output width
    localparam int ANG_W = 32;  // binary angle, 2^32 per turn
    localparam int Z_W   = 33;  // residual angle

    localparam logic [29:0] GAIN_Q30  = 30'd652032874;
    localparam logic [30:0] SPEED_Q24 = 31'd3162431;
    localparam logic [30:0] TURN_Q16  = 31'd527765581;

    // bearing to binary angle: (mag * 2^23 + 22) / 45
    localparam int          DIV_NUM_W  = 38;
    localparam int          DIV_CNT_W  = 6;
    localparam logic [6:0]  DIVISOR    = 7'd45;
    localparam logic [22:0] BEAR_ROUND = 23'd22;

    // configuration register indexes
    localparam logic [7:0] REG_LANDMARK_X    = 8'd0;
    localparam logic [7:0] REG_LANDMARK_Y    = 8'd1;
    localparam logic [7:0] REG_CAMERA_OFFSET = 8'd2;
    localparam logic [7:0] REG_MISS_LIMIT    = 8'd3;

    typedef enum logic [1:0] {
        OP_CAMERA = 2'd0,
        OP_WHEEL  = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_ROT1,
        ST_ROT2,
        ST_VMUL,
        ST_VTURN,
        ST_VSTART,
        ST_VROT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MULX,
        CS_MULY,
        CS_ITER,
        CS_ROUND
    } cord_state_t;

    // rotation request and response
    typedef struct packed {
        logic                   start;
        logic signed [IO_W-1:0] x;
        logic signed [IO_W-1:0] y;
        logic [ANG_W-1:0]       ang;
    } cord_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [IO_W-1:0] x;
        logic signed [IO_W-1:0] y;
    } cord_rsp_t;

    // arctangent of 2^-i in 2^32 per turn
    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:    r = 30'h20000000;
            5'd1:    r = 30'h12E4051E;
            5'd2:    r = 30'h09FB385B;
            5'd3:    r = 30'h051111D4;
            5'd4:    r = 30'h028B0D43;
            5'd5:    r = 30'h0145D7E1;
            5'd6:    r = 30'h00A2F61E;
            5'd7:    r = 30'h00517C55;
            5'd8:    r = 30'h0028BE53;
            5'd9:    r = 30'h00145F2F;
            5'd10:   r = 30'h000A2F98;
            5'd11:   r = 30'h000517CC;
            5'd12:   r = 30'h00028BE6;
            5'd13:   r = 30'h000145F3;
            5'd14:   r = 30'h0000A2FA;
            5'd15:   r = 30'h0000517D;
            5'd16:   r = 30'h000028BE;
            5'd17:   r = 30'h0000145F;
            5'd18:   r = 30'h00000A30;
            5'd19:   r = 30'h00000518;
            5'd20:   r = 30'h0000028C;
            5'd21:   r = 30'h00000146;
            5'd22:   r = 30'h000000A3;
            5'd23:   r = 30'h00000051;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

    // clamp to 16 bit signed
    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* src/landmark_odometry_measurement.sv */
// Top level of the landmark odometry measurement front end.
//
// Input items arrive on s_tvalid/s_tready; s_tuser carries the operation
// (camera, wheel speeds, tick) and s_tdata the measurement fields. Every
// accepted item gives one result item on m_tvalid/m_tready carrying the held
// position, velocity, heading and tracking flags. Register writes come over
// cfg_valid/cfg_ready (always ready) and must be made only while idle; the block
// itself does not enforce it. Items are handled one at a time. A tick or a
// miss goes from dispatch straight to the finish step, a wheel item takes a
// constant multiply, then one rotation, a detection a bit-serial divide for
// the bearing, then two CORDIC rotations in the one shared rotator.
// The result sits in an output register, so the next item is taken while
// it waits; a stalled receiver holds the finished item until the output
// register frees. Reset clears heading, turn step, tracking state and held
// values and restores the register defaults; no result is pending after it.
`include "landmark_odometry_measurement_defines.svh"
module landmark_odometry_measurement
    import lomeas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // detected, distance, bearing, right_wheel_speed, left_wheel_speed
    input  logic [1:0]  s_tuser,   // operation
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // position_x, position_y, velocity_x, velocity_y,
                                   // heading_angle, position_fresh, tracking_on,
                                   // tracking_started, zero fill
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic               det_reg;
    logic [15:0]        dist_reg;
    logic signed [14:0] bear_reg;
    logic signed [15:0] right_reg, left_reg;

    logic signed [15:0] lx_reg, ly_reg;
    logic [11:0]        offset_reg;
    logic [7:0]         limit_reg;

    logic [31:0]        heading_reg, turn_reg;
    logic               track_reg;
    logic [7:0]         miss_reg;
    logic [15:0]        pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;

    logic signed [48:0] prod_reg;
    logic signed [17:0] speed_reg;
    logic [31:0]        turn_new_reg;

    logic               m_tvalid_reg;
    logic [87:0]        m_tdata_reg;

    logic               out_free, out_load, div_start, div_done;
    logic [14:0]        bear_mag;
    logic [31:0]        div_quot, bear_ang;
    cord_req_t          creq;
    cord_rsp_t          crsp;

    logic signed [16:0] wsum, wdiff, mul_a;
    logic [30:0]        mul_c;
    logic signed [48:0] prod_next, t24, t16;

    logic [31:0]        heading_n;
    logic               track_n, fresh_n, started_n;
    logic [7:0]         miss_n, miss_inc;
    logic [15:0]        pos_x_n, pos_y_n, vel_x_n, vel_y_n;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (op_reg)
                    OP_CAMERA: state_next = det_reg ? ST_DIV : ST_FINISH;
                    OP_WHEEL:  state_next = ST_VMUL;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_DIV:      if (div_done) state_next = ST_ROT1;
            ST_ROT1:     if (crsp.done) state_next = ST_ROT2;
            ST_ROT2:     if (crsp.done) state_next = ST_FINISH;
            ST_VMUL:     state_next = ST_VTURN;
            ST_VTURN:    state_next = ST_VSTART;
            ST_VSTART:   state_next = ST_VROT;
            ST_VROT:     if (crsp.done) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // bearing magnitude and signed angle
    always_comb begin
        bear_mag = bear_reg[14] ? 15'(-{bear_reg[14], bear_reg}) : 15'(bear_reg);
        bear_ang = bear_reg[14] ? -div_quot : div_quot;
    end

    // control outputs and rotator request
    always_comb begin
        div_start  = 1'b0;
        out_load   = 1'b0;
        creq.start = 1'b0;
        creq.x     = IO_W'($signed({1'b0, dist_reg}));
        creq.y     = '0;
        creq.ang   = bear_ang;
        unique case (state_reg)
            ST_DISPATCH: div_start = (op_reg == OP_CAMERA) && det_reg;
            ST_DIV:      creq.start = div_done;
            ST_ROT1: begin
                creq.start = crsp.done;
                creq.x     = crsp.x + IO_W'($signed({1'b0, offset_reg}));
                creq.y     = crsp.y;
                creq.ang   = heading_reg;
            end
            ST_VSTART: begin
                creq.start = 1'b1;
                creq.x     = speed_reg;
                creq.ang   = heading_reg;
            end
            ST_FINISH:   out_load = out_free;
            default: ;
        endcase
    end

    // shared constant multiplier for wheel items
    always_comb begin
        wsum      = {right_reg[15], right_reg} + {left_reg[15], left_reg};
        wdiff     = {right_reg[15], right_reg} - {left_reg[15], left_reg};
        mul_a     = (state_reg == ST_VMUL) ? wsum : wdiff;
        mul_c     = (state_reg == ST_VMUL) ? SPEED_Q24 : TURN_Q16;
        prod_next = 49'(mul_a * $signed({1'b0, mul_c}));
        t24       = prod_reg + (prod_reg[48] ? 49'sd8388607 : 49'sd8388608);
        t16       = prod_reg + (prod_reg[48] ? 49'sd32767 : 49'sd32768);
    end

    // state update at the end of an item
    always_comb begin
        heading_n = heading_reg;
        track_n   = track_reg;
        miss_n    = miss_reg;
        pos_x_n   = pos_x_reg;
        pos_y_n   = pos_y_reg;
        vel_x_n   = vel_x_reg;
        vel_y_n   = vel_y_reg;
        fresh_n   = 1'b0;
        started_n = 1'b0;
        miss_inc  = (miss_reg == 8'hFF) ? miss_reg : miss_reg + 1'b1;
        case (op_reg)
            OP_CAMERA: begin
                if (det_reg) begin
                    miss_n    = '0;
                    track_n   = 1'b1;
                    started_n = !track_reg;
                    fresh_n   = 1'b1;
                    pos_x_n   = sat16(19'(lx_reg) - 19'(crsp.x));
                    pos_y_n   = sat16(19'(ly_reg) - 19'(crsp.y));
                end else if (track_reg) begin
                    miss_n  = miss_inc;
                    track_n = !(miss_inc >= limit_reg);
                end
            end
            OP_WHEEL: begin
                vel_x_n = sat16(19'(crsp.x));
                vel_y_n = sat16(19'(crsp.y));
            end
            OP_TICK:  heading_n = heading_reg + turn_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            lx_reg       <= 16'sd1024;
            ly_reg       <= 16'sd1024;
            offset_reg   <= 12'd26;
            limit_reg    <= 8'd5;
            heading_reg  <= '0;
            turn_reg     <= '0;
            track_reg    <= 1'b0;
            miss_reg     <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
        end else begin
            state_reg <= state_next;
            // register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_LANDMARK_X:    lx_reg     <= cfg_data;
                    REG_LANDMARK_Y:    ly_reg     <= cfg_data;
                    REG_CAMERA_OFFSET: offset_reg <= cfg_data[11:0];
                    REG_MISS_LIMIT:    limit_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            // result handoff
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (out_load) begin
                heading_reg <= heading_n;
                track_reg   <= track_n;
                miss_reg    <= miss_n;
                pos_x_reg   <= pos_x_n;
                pos_y_reg   <= pos_y_n;
                vel_x_reg   <= vel_x_n;
                vel_y_reg   <= vel_y_n;
                if (op_reg == OP_WHEEL) begin
                    turn_reg <= turn_new_reg;
                end
            end
        end
        // item capture
        if (s_tvalid && s_tready) begin
            op_reg    <= op_t'(s_tuser);
            det_reg   <= s_tdata[0];
            dist_reg  <= s_tdata[16:1];
            bear_reg  <= s_tdata[31:17];
            right_reg <= s_tdata[47:32];
            left_reg  <= s_tdata[63:48];
        end
        // wheel arithmetic
        if (state_reg == ST_VMUL || state_reg == ST_VTURN) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_VTURN) begin
            speed_reg <= t24[41:24];
        end
        if (state_reg == ST_VSTART) begin
            turn_new_reg <= t16[47:16];
        end
        if (out_load) begin
            m_tdata_reg <= {5'b0, started_n, track_n, fresh_n, heading_n[31:16],
                            vel_y_n, vel_x_n, pos_y_n, pos_x_n};
        end
    end

    lomeas_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (bear_mag),
        .done    (div_done),
        .quot    (div_quot)
    );

    lomeas_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    // a new track and a fresh position both mean tracking is on
    `LOM_CHECK_IMP(a_started_on, m_tvalid && m_tdata[82], m_tdata[81])
    `LOM_CHECK_IMP(a_fresh_on, m_tvalid && m_tdata[80], m_tdata[81])
    // a finished item shows up on the result channel
    `LOM_CHECK_NXT(a_load_shows, out_load, m_tvalid_reg)

endmodule

/* src/lomeas_div.sv */
// Bit-serial restoring divider turning a bearing magnitude into a binary angle.
module lomeas_div
    import lomeas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [14:0] mag,
    output logic        done,
    output logic [31:0] quot
);

    logic [DIV_NUM_W-1:0] work_reg, work_next;
    logic [5:0]           rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [6:0]           trial;
    logic                 qbit;

    // one quotient bit per cycle; dividend bits leave at the top, quotient enters below
    always_comb begin
        trial     = {rem_reg, work_reg[DIV_NUM_W-1]};
        qbit      = (trial >= DIVISOR);
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = {mag, BEAR_ROUND};
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[DIV_NUM_W-2:0], qbit};
            rem_next  = qbit ? 6'(trial - DIVISOR) : trial[5:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = work_reg[31:0];

endmodule

/* src/lomeas_cordic.sv */
// Iterative CORDIC rotator, one micro-rotation per cycle.
module lomeas_cordic
    import lomeas_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cord_req_t req,
    output cord_rsp_t rsp
);

    cord_state_t            state_reg, state_next;
    logic signed [IO_W-1:0] xin_reg, yin_reg;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [4:0]             i_reg, i_next;
    logic signed [IO_W-1:0] ox_reg, oy_reg;
    logic                   done_reg;
    logic                   flip;
    logic [ANG_W-1:0]       ang_f;
    logic signed [IO_W-1:0] mul_in;
    logic signed [XY_W-1:0] mul_out;
    logic signed [XY_W-1:0] dx, dy, xr, yr;
    logic signed [Z_W-1:0]  step_ang;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:  if (req.start) state_next = CS_MULX;
            CS_MULX:  state_next = CS_MULY;
            CS_MULY:  state_next = CS_ITER;
            CS_ITER:  if (i_reg == 5'(CORDIC_ITERS - 1)) state_next = CS_ROUND;
            CS_ROUND: state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    // fold into [-90, 90) degrees by a half turn
    always_comb begin
        flip  = (req.ang[31:30] == 2'b01) || (req.ang[31:30] == 2'b10);
        ang_f = {req.ang[31] ^ flip, req.ang[30:0]};
    end

    // gain scaling, one multiplier shared by both coordinates
    always_comb begin
        mul_in  = (state_reg == CS_MULX) ? xin_reg : yin_reg;
        mul_out = XY_W'(mul_in * $signed({1'b0, GAIN_Q30}));
    end

    // micro-rotation and rounding
    always_comb begin
        dx       = y_reg >>> i_reg;
        dy       = x_reg >>> i_reg;
        step_ang = $signed({3'b0, atan_entry(i_reg)});
        xr       = x_reg + (x_reg[XY_W-1] ? XY_W'(536870911) : XY_W'(536870912));
        yr       = y_reg + (y_reg[XY_W-1] ? XY_W'(536870911) : XY_W'(536870912));
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        i_next   = i_reg;
        unique case (state_reg)
            CS_IDLE: begin
                z_next = $signed({ang_f[31], ang_f});
                i_next = '0;
            end
            CS_MULX: x_next = mul_out;
            CS_MULY: y_next = mul_out;
            CS_ITER: begin
                if (!z_reg[Z_W-1]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - step_ang;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + step_ang;
                end
                i_next = i_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == CS_ROUND);
        end
        if (state_reg == CS_IDLE && req.start) begin
            xin_reg <= flip ? -req.x : req.x;
            yin_reg <= flip ? -req.y : req.y;
        end
        if (state_reg == CS_ROUND) begin
            ox_reg <= xr[47:30];
            oy_reg <= yr[47:30];
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = ox_reg;
    assign rsp.y    = oy_reg;

endmodule

/* test/landmark_odometry_measurement_checker.sv */
// Result predictor and scoreboard for the landmark odometry measurement block.
module landmark_odometry_measurement_checker
    import lomeas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam longint SPEED_K = 3162431;
    localparam longint TURN_K  = 527765581;
    localparam longint GAIN_K  = 652032874;

    // predictor copy of registers and state
    logic signed [15:0] lm_x, lm_y;
    logic [11:0]        cam_off;
    logic [7:0]         miss_lim;
    logic [31:0]        heading, turn;
    logic               tracking;
    logic [7:0]         misses;
    logic signed [15:0] pos_x, pos_y, vel_x, vel_y;

    logic [87:0] expected_results[$];

    assign pending_count = expected_results.size();

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (s - 1))) >> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // CORDIC rotation of (x, y) by a binary angle, folded into the right half plane
    task automatic cordic_rotate(input longint x, input longint y, input logic [31:0] ang,
                                 output longint ox, output longint oy);
        longint xa, ya, za, dx, dy;
        logic [31:0] a;
        a = ang;
        if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
            x = -x;
            y = -y;
            a = a + 32'h80000000;
        end
        za = longint'($signed(a));
        xa = x * GAIN_K;
        ya = y * GAIN_K;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = floor_sh(ya, i);
            dy = floor_sh(xa, i);
            if (za >= 0) begin
                xa -= dx; ya += dy; za -= longint'(atan_entry(i[4:0]));
            end else begin
                xa += dx; ya -= dy; za += longint'(atan_entry(i[4:0]));
            end
        end
        ox = round_sh(xa, 30);
        oy = round_sh(ya, 30);
    endtask

    // advance the predictor by one input item and return the expected result
    task automatic predict_measurement(input op_t op, input logic [63:0] d,
                                       output logic [87:0] res);
        logic fresh, started;
        longint b, mag, xc, yc, rx, ry, r, l, v, ts, vx, vy;
        fresh = 0;
        started = 0;
        case (op)
            OP_CAMERA: begin
                if (d[0]) begin
                    b = longint'($signed(d[31:17]));
                    mag = (b < 0) ? -b : b;
                    mag = (mag * 8388608 + 22) / 45;
                    if (b < 0) mag = -mag;
                    misses = 0;
                    if (!tracking) begin
                        tracking = 1;
                        started = 1;
                    end
                    cordic_rotate(longint'(d[16:1]), 0, mag[31:0], xc, yc);
                    xc += longint'(cam_off);
                    cordic_rotate(xc, yc, heading, rx, ry);
                    pos_x = clamp16(longint'(lm_x) - rx);
                    pos_y = clamp16(longint'(lm_y) - ry);
                    fresh = 1;
                end else if (tracking) begin
                    if (misses != 8'd255) misses++;
                    if (misses >= miss_lim) tracking = 0;
                end
            end
            OP_WHEEL: begin
                r = longint'($signed(d[47:32]));
                l = longint'($signed(d[63:48]));
                v = round_sh((r + l) * SPEED_K, 24);
                ts = round_sh((r - l) * TURN_K, 16);
                cordic_rotate(v, 0, heading, vx, vy);
                vel_x = clamp16(vx);
                vel_y = clamp16(vy);
                turn = ts[31:0];
            end
            OP_TICK: heading = heading + turn;
            default: ;
        endcase
        res = {5'd0, started, tracking, fresh, heading[31:16], vel_y, vel_x, pos_y, pos_x};
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [87:0] res, want;
        if (!aresetn) begin
            lm_x <= 16'sd1024; lm_y <= 16'sd1024; cam_off <= 12'd26; miss_lim <= 8'd5;
            heading <= '0; turn <= '0; tracking <= 0; misses <= '0;
            pos_x <= '0; pos_y <= '0; vel_x <= '0; vel_y <= '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LANDMARK_X:    lm_x = cfg_data;
                    REG_LANDMARK_Y:    lm_y = cfg_data;
                    REG_CAMERA_OFFSET: cam_off = cfg_data[11:0];
                    REG_MISS_LIMIT:    miss_lim = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_measurement(op_t'(s_tuser), s_tdata, res);
                expected_results = {expected_results, res};
            end
            // compare the result item field by field
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[15:0] !== want[15:0])
                        report("position_x", m_tdata[15:0], want[15:0]);
                    if (m_tdata[31:16] !== want[31:16])
                        report("position_y", m_tdata[31:16], want[31:16]);
                    if (m_tdata[47:32] !== want[47:32])
                        report("velocity_x", m_tdata[47:32], want[47:32]);
                    if (m_tdata[63:48] !== want[63:48])
                        report("velocity_y", m_tdata[63:48], want[63:48]);
                    if (m_tdata[79:64] !== want[79:64])
                        report("heading_angle", m_tdata[79:64], want[79:64]);
                    if (m_tdata[80] !== want[80])
                        report("position_fresh", m_tdata[80], want[80]);
                    if (m_tdata[81] !== want[81])
                        report("tracking_on", m_tdata[81], want[81]);
                    if (m_tdata[82] !== want[82])
                        report("tracking_started", m_tdata[82], want[82]);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* test/landmark_odometry_measurement_test.sv */
// Stimulus and verdict for the landmark odometry measurement block.
module landmark_odometry_measurement_test;
    import lomeas_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending_count;
    int          burst_left = 0;
    logic        stall_mode = 0;

    always #1 aclk = ~aclk;

    landmark_odometry_measurement DUT (.*);
    landmark_odometry_measurement_checker scoreboard (.*);

    // receiver stalls in phases: free running, or random backpressure
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // back to back writes keep cfg_valid high; the caller drops it after the last one
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // send one item; bursts of back to back items with random gaps between
    task automatic send_item(input op_t op, input logic det, input logic [15:0] range_val,
                             input logic [14:0] bear, input logic [15:0] rw,
                             input logic [15:0] lw);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1; s_tuser <= op; s_tdata <= {lw, rw, bear, range_val, det};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic random_item;
        int k;
        logic [15:0] range_val;
        logic [14:0] bear;
        k = $urandom_range(0, 99);
        range_val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 2000));
        bear = ($urandom_range(0, 7) == 0) ? 15'($urandom)
                                          : 15'($signed($urandom_range(0, 23040)) - 11520);
        if (k < 35)      send_item(OP_CAMERA, $urandom_range(0, 2) != 0, range_val, bear, 0, 0);
        else if (k < 55) send_item(OP_WHEEL, 0, 0, 0,
                                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(0, 1000)) - 500),
                                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(0, 1000)) - 500));
        else if (k < 97) send_item(OP_TICK, 0, 0, 0, 0, 0);
        else             send_item(OP_NONE, $urandom_range(0, 1), 16'($urandom),
                                   15'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: defaults, extremes of each field and the tracking cases
        send_item(OP_CAMERA, 0, 0, 0, 0, 0);
        send_item(OP_CAMERA, 1, 16'd1000, 15'd0, 0, 0);
        send_item(OP_CAMERA, 1, 16'hFFFF, 15'sd11520, 0, 0);
        send_item(OP_CAMERA, 1, 16'd0, -15'sd11520, 0, 0);
        send_item(OP_CAMERA, 1, 16'd500, 15'h7FFF, 0, 0);
        send_item(OP_CAMERA, 1, 16'd500, 15'h4000, 0, 0);
        send_item(OP_WHEEL, 0, 0, 0, 16'h7FFF, 16'h8000);
        repeat (3) send_item(OP_TICK, 0, 0, 0, 0, 0);
        send_item(OP_WHEEL, 0, 0, 0, 16'h7FFF, 16'h7FFF);
        send_item(OP_WHEEL, 0, 0, 0, 16'h8000, 16'h8000);
        send_item(OP_CAMERA, 1, 16'd3000, 15'd2000, 0, 0);
        repeat (6) send_item(OP_CAMERA, 0, 16'hFFFF, 15'h7FFF, 0, 0);
        send_item(OP_NONE, 1, 16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_WHEEL, 0, 0, 0, 16'd0, 16'd0);
        drain();
        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_LANDMARK_X, 16'h7FFF); write_reg(REG_LANDMARK_Y, 16'h8000);
                    write_reg(REG_CAMERA_OFFSET, 16'd2560); write_reg(REG_MISS_LIMIT, 16'd1);
                end
                1: begin
                    write_reg(REG_LANDMARK_X, 16'h8000); write_reg(REG_LANDMARK_Y, 16'h7FFF);
                    write_reg(REG_CAMERA_OFFSET, 16'd0); write_reg(REG_MISS_LIMIT, 16'd255);
                end
                default: begin
                    write_reg(REG_LANDMARK_X, 16'($urandom));
                    write_reg(REG_LANDMARK_Y, 16'($urandom));
                    write_reg(REG_CAMERA_OFFSET, 16'($urandom_range(0, 2560)));
                    write_reg(REG_MISS_LIMIT, 16'($urandom_range(1, 255)));
                end
            endcase
            cfg_valid <= 0;
            repeat (200) random_item();
            drain();
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* landmark_odometry_measurement.f */
+incdir+src
src/lomeas_pkg.sv
src/lomeas_div.sv
src/lomeas_cordic.sv
src/landmark_odometry_measurement.sv
test/landmark_odometry_measurement_checker.sv
test/landmark_odometry_measurement_test.sv
